// File: sv/isg_pkg.sv
package isg_pkg;

  // Segment kinds, as reported on the result channel.
  typedef enum logic [2:0] {
    KindPlain        = 3'd0,
    KindBinhex       = 3'd1,
    KindPostscript   = 3'd2,
    KindPgpSigned    = 3'd3,
    KindPgpEncrypted = 3'd4
  } isg_kind_e;

  // Index of a start marker; its kind is the index plus one.
  localparam logic [1:0] OpenBinhex       = 2'd0;
  localparam logic [1:0] OpenPostscript   = 2'd1;
  localparam logic [1:0] OpenPgpSigned    = 2'd2;
  localparam logic [1:0] OpenPgpEncrypted = 2'd3;
  localparam int unsigned OpenCount = 4;

  localparam int unsigned OffsetBitsDefault   = 32;
  localparam int unsigned MaxMarkerLenDefault = 45;
  localparam int unsigned MarkPosW            = 6;
  localparam int unsigned FifoDepth           = 4;

  localparam logic [7:0] Newline = 8'h0A;
  localparam logic [7:0] Colon   = 8'h3A;

  localparam int OpenLen0  = 45;
  localparam int OpenLen1  = 11;
  localparam int OpenLen2  = 34;
  localparam int OpenLen3  = 27;
  localparam int CloseLen2 = 5;
  localparam int CloseLen3 = 27;
  localparam int CloseLen4 = 25;

  localparam logic [8*OpenLen0-1:0] OpenMark0 =
    "(This file must be converted with BinHex 4.0)";
  localparam logic [8*OpenLen1-1:0] OpenMark1 = "%!PS-Adobe-";
  localparam logic [8*OpenLen2-1:0] OpenMark2 = "-----BEGIN PGP SIGNED MESSAGE-----";
  localparam logic [8*OpenLen3-1:0] OpenMark3 = "-----BEGIN PGP MESSAGE-----";
  localparam logic [8*CloseLen2-1:0] CloseMark2 = "%%EOF";
  localparam logic [8*CloseLen3-1:0] CloseMark3 = "-----END PGP SIGNATURE-----";
  localparam logic [8*CloseLen4-1:0] CloseMark4 = "-----END PGP MESSAGE-----";

  typedef struct packed {
    logic [2:0]  segment_kind;
    logic [31:0] segment_start;
    logic [31:0] segment_length;
    logic        stream_end;
  } isg_rec_t;

  // Records produced by one accepted item; rec1 is used only with rec0.
  typedef struct packed {
    logic     vld0;
    logic     vld1;
    isg_rec_t rec0;
    isg_rec_t rec1;
  } isg_push_t;

  function automatic logic [MarkPosW-1:0] open_len(logic [1:0] idx);
    logic [MarkPosW-1:0] len;
    case (idx)
      OpenBinhex:     len = MarkPosW'(OpenLen0);
      OpenPostscript: len = MarkPosW'(OpenLen1);
      OpenPgpSigned:  len = MarkPosW'(OpenLen2);
      default:        len = MarkPosW'(OpenLen3);
    endcase
    return len;
  endfunction

  // Byte of a start marker at a line position; zero past the marker's end.
  function automatic logic [7:0] open_byte(logic [1:0] idx, logic [MarkPosW-1:0] pos);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      OpenBinhex:
        if (int'(pos) < OpenLen0) b = OpenMark0[8*(OpenLen0-1-int'(pos)) +: 8];
      OpenPostscript:
        if (int'(pos) < OpenLen1) b = OpenMark1[8*(OpenLen1-1-int'(pos)) +: 8];
      OpenPgpSigned:
        if (int'(pos) < OpenLen2) b = OpenMark2[8*(OpenLen2-1-int'(pos)) +: 8];
      default:
        if (int'(pos) < OpenLen3) b = OpenMark3[8*(OpenLen3-1-int'(pos)) +: 8];
    endcase
    return b;
  endfunction

  function automatic logic [MarkPosW-1:0] close_len(isg_kind_e kind);
    logic [MarkPosW-1:0] len;
    case (kind)
      KindPostscript:   len = MarkPosW'(CloseLen2);
      KindPgpSigned:    len = MarkPosW'(CloseLen3);
      KindPgpEncrypted: len = MarkPosW'(CloseLen4);
      default:          len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] close_byte(isg_kind_e kind, logic [MarkPosW-1:0] pos);
    logic [7:0] b;
    b = 8'h00;
    case (kind)
      KindPostscript:
        if (int'(pos) < CloseLen2) b = CloseMark2[8*(CloseLen2-1-int'(pos)) +: 8];
      KindPgpSigned:
        if (int'(pos) < CloseLen3) b = CloseMark3[8*(CloseLen3-1-int'(pos)) +: 8];
      KindPgpEncrypted:
        if (int'(pos) < CloseLen4) b = CloseMark4[8*(CloseLen4-1-int'(pos)) +: 8];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: sv/isg_in_if.sv
interface isg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// File: sv/isg_out_if.sv
interface isg_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  segment_kind;
  logic [31:0] segment_start;
  logic [31:0] segment_length;
  logic        stream_end;

  modport source (output valid, output segment_kind, output segment_start,
                  output segment_length, output stream_end, input ready);
  modport sink (input valid, input segment_kind, input segment_start,
                input segment_length, input stream_end, output ready);
endinterface

// File: sv/isg_scan.sv
module isg_scan #(
  parameter int unsigned OFFSET_BITS    = isg_pkg::OffsetBitsDefault,
  parameter int unsigned MAX_MARKER_LEN = isg_pkg::MaxMarkerLenDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_stream_i,
  output isg_pkg::isg_push_t push_o
);

  localparam int unsigned PosW = $clog2(MAX_MARKER_LEN + 1);
  localparam int unsigned OutW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

  isg_pkg::isg_kind_e     kind_q, kind_d;
  logic [PosW-1:0]        pos_q, pos_d, pos_n;
  logic [3:0]             sc_q, sc_d, sc_n;
  logic                   ec_q, ec_d, ec_n;
  logic [7:0]             prev_q, prev_d, prev_n;
  logic [OFFSET_BITS-1:0] ofs_q, ofs_d, seg_q, seg_d, line_q, line_d, nxt;

  logic                          nl, line_end, found, close, a_take, a_vld, b_vld;
  logic [1:0]                    found_idx;
  logic [isg_pkg::MarkPosW-1:0]  mpos;
  logic [OFFSET_BITS-1:0]        a_from, a_to;
  isg_pkg::isg_kind_e            a_kind;
  isg_pkg::isg_rec_t             rec_a, rec_b, rec_fb;

  function automatic logic [31:0] clamp_out(logic [OFFSET_BITS-1:0] v);
    logic [OutW-1:0] ext;
    ext = OutW'(v);
    return (ext > OutW'(33'hFFFF_FFFF)) ? 32'hFFFF_FFFF : ext[31:0];
  endfunction

  function automatic isg_pkg::isg_rec_t mk_rec(isg_pkg::isg_kind_e kind,
                                              logic [OFFSET_BITS-1:0] from,
                                              logic [OFFSET_BITS-1:0] to);
    isg_pkg::isg_rec_t r;
    r.segment_kind   = kind;
    r.segment_start  = clamp_out(from);
    r.segment_length = clamp_out(to - from);
    r.stream_end     = 1'b0;
    return r;
  endfunction

  always_comb begin
    nl       = (data_byte_i == isg_pkg::Newline);
    line_end = nl || end_of_stream_i;
    nxt      = (&ofs_q) ? ofs_q : ofs_q + 1'b1;
    mpos     = isg_pkg::MarkPosW'(pos_q);

    // Marker tracking for the byte just taken.
    for (int i = 0; i < isg_pkg::OpenCount; i++) begin
      sc_n[i] = sc_q[i] & (nl || pos_q >= PosW'(isg_pkg::open_len(2'(i))) ||
                data_byte_i == isg_pkg::open_byte(2'(i), mpos));
    end
    ec_n = ec_q;
    if (!nl && (kind_q inside {isg_pkg::KindPostscript, isg_pkg::KindPgpSigned,
                               isg_pkg::KindPgpEncrypted})) begin
      if (pos_q < PosW'(isg_pkg::close_len(kind_q)) &&
          data_byte_i != isg_pkg::close_byte(kind_q, mpos)) begin
        ec_n = 1'b0;
      end
    end
    prev_n = nl ? prev_q : data_byte_i;
    pos_n  = (nl || pos_q == PosW'(MAX_MARKER_LEN)) ? pos_q : pos_q + 1'b1;

    // The lowest-numbered matching start marker wins.
    found     = 1'b0;
    found_idx = 2'd0;
    for (int i = isg_pkg::OpenCount - 1; i >= 0; i--) begin
      if (sc_n[i] && pos_n >= PosW'(isg_pkg::open_len(2'(i)))) begin
        found     = 1'b1;
        found_idx = 2'(i);
      end
    end

    case (kind_q)
      isg_pkg::KindBinhex: close = (pos_n != '0) && (prev_n == isg_pkg::Colon);
      isg_pkg::KindPostscript, isg_pkg::KindPgpSigned, isg_pkg::KindPgpEncrypted:
        close = ec_n && (pos_n >= PosW'(isg_pkg::close_len(kind_q)));
      default: close = 1'b0;
    endcase

    kind_d = kind_q;
    seg_d  = seg_q;
    a_take = 1'b0;
    a_kind = kind_q;
    a_from = seg_q;
    a_to   = nxt;
    if (line_end) begin
      if (kind_q == isg_pkg::KindPlain) begin
        if (found) begin
          a_take = 1'b1;
          a_to   = line_q;
          seg_d  = line_q;
          kind_d = isg_pkg::isg_kind_e'({1'b0, found_idx} + 3'd1);
        end
      end else if (close) begin
        a_take = 1'b1;
        seg_d  = nxt;
        kind_d = isg_pkg::KindPlain;
      end
    end
    a_vld = a_take && (a_to > a_from);
    b_vld = end_of_stream_i && (nxt > seg_d);

    rec_a  = mk_rec(a_kind, a_from, a_to);
    rec_b  = mk_rec(isg_pkg::KindPlain, seg_d, nxt);
    rec_fb.segment_kind   = isg_pkg::KindPlain;
    rec_fb.segment_start  = clamp_out(seg_d);
    rec_fb.segment_length = 32'd1;
    rec_fb.stream_end     = 1'b0;

    push_o      = '0;
    push_o.rec1 = rec_b;
    if (a_vld) begin
      push_o.rec0 = rec_a;
    end else if (b_vld) begin
      push_o.rec0 = rec_b;
    end else begin
      push_o.rec0 = rec_fb;
    end
    push_o.vld0 = take_i && (a_vld || end_of_stream_i);
    push_o.vld1 = take_i && a_vld && b_vld;
    push_o.rec1.stream_end = 1'b1;
    push_o.rec0.stream_end = end_of_stream_i && !(a_vld && b_vld);

    // Next state: a stream end returns everything to the reset state.
    if (end_of_stream_i) begin
      kind_d = isg_pkg::KindPlain;
      seg_d  = '0;
      line_d = '0;
      ofs_d  = '0;
    end else begin
      line_d = line_end ? nxt : line_q;
      ofs_d  = nxt;
    end
    if (line_end) begin
      pos_d  = '0;
      sc_d   = '1;
      ec_d   = 1'b1;
      prev_d = 8'h00;
    end else begin
      pos_d  = pos_n;
      sc_d   = sc_n;
      ec_d   = ec_n;
      prev_d = prev_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= isg_pkg::KindPlain;
      pos_q  <= '0;
      sc_q   <= '1;
      ec_q   <= 1'b1;
      prev_q <= 8'h00;
      ofs_q  <= '0;
      seg_q  <= '0;
      line_q <= '0;
    end else if (take_i) begin
      kind_q <= kind_d;
      pos_q  <= pos_d;
      sc_q   <= sc_d;
      ec_q   <= ec_d;
      prev_q <= prev_d;
      ofs_q  <= ofs_d;
      seg_q  <= seg_d;
      line_q <= line_d;
    end
  end

endmodule

// File: sv/isg_fifo.sv
module isg_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  isg_pkg::isg_push_t push_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output isg_pkg::isg_rec_t  rec_o
);

  localparam int unsigned Depth = isg_pkg::FifoDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  isg_pkg::isg_rec_t mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];
  // Room is kept for the two records a single item can produce.
  assign room_o  = (cnt_q <= CntW'(Depth - 2));

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.vld0) + PtrW'(push_i.vld1);
    rd_d  = rd_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(push_i.vld0) + CntW'(push_i.vld1) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.vld0) begin
      mem_q[wr_q] <= push_i.rec0;
    end
    if (push_i.vld1) begin
      mem_q[wr_q + 1'b1] <= push_i.rec1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: sv/inline_part_segmenter_unit.sv
// Channel  Role    Fields                                                  Item
// in_i     sink    data_byte, end_of_stream                                one byte
// out_o    source  segment_kind, segment_start, segment_length, stream_end one segment
//
// One byte is taken per cycle while in_i.ready is high; the records it
// closes, at most two, go into a four-entry queue in the same cycle and are
// offered on out_o from the next cycle, one per cycle unless out_o stalls.
// in_i.ready drops while the queue holds more than two records, so a stall on
// out_o holds the input back only once three records are waiting.
// After reset the block is at offset 0 in plain mode and takes a byte at once.
module inline_part_segmenter_unit #(
  parameter int unsigned OFFSET_BITS    = isg_pkg::OffsetBitsDefault,
  parameter int unsigned MAX_MARKER_LEN = isg_pkg::MaxMarkerLenDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  isg_in_if.sink    in_i,
  isg_out_if.source out_o
);

  isg_pkg::isg_push_t push;
  isg_pkg::isg_rec_t  rec;
  logic               room, take;

  assign take     = in_i.valid && in_i.ready;
  assign in_i.ready = room;

  isg_scan #(
    .OFFSET_BITS   (OFFSET_BITS),
    .MAX_MARKER_LEN(MAX_MARKER_LEN)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .data_byte_i    (in_i.data_byte),
    .end_of_stream_i(in_i.end_of_stream),
    .push_o         (push)
  );

  isg_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(out_o.valid),
    .ready_i(out_o.ready),
    .rec_o  (rec)
  );

  assign out_o.segment_kind   = rec.segment_kind;
  assign out_o.segment_start  = rec.segment_start;
  assign out_o.segment_length = rec.segment_length;
  assign out_o.stream_end     = rec.stream_end;

  // A stream end always leaves a closing record in the queue.
  a_eos_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && in_i.end_of_stream |-> push.vld0 &&
      (push.rec0.stream_end || (push.vld1 && push.rec1.stream_end)))
    else $error("stream end without a closing record");

  // A second record only follows a first one and only at a stream end.
  a_second_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.vld1 |-> push.vld0 && in_i.end_of_stream && !push.rec0.stream_end)
    else $error("second record out of place");

  // Records are pushed only for an accepted item.
  a_push_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.vld0 |-> take)
    else $error("record pushed without an item");

  // Reported segments are never empty.
  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.segment_length != 32'd0)
    else $error("empty segment reported");

endmodule
